/* rtl/ffsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types, codes and sizes shared by the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int SEG_N  = 1024;
  localparam int IDX_W  = $clog2(SEG_N);
  localparam int CNT_W  = IDX_W + 1;
  localparam int ADDR_W = 16;
  localparam int LEN_W  = 17;

  localparam logic [LEN_W-1:0] POOL_LIMIT = LEN_W'(65536);

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_NOSPARE = 3'd2;
  localparam logic [2:0] ST_NOADDR  = 3'd3;
  localparam logic [2:0] ST_BADSIZE = 3'd4;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [LEN_W-1:0]  request_size;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic [LEN_W-1:0]  bytes_free;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] base;
  } seg_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_APPLY, S_MRD, S_MCHK, S_MSCAN, S_MWR, S_MDEL, S_DONE
  } state_t;

endpackage

/* rtl/first_fit_segment_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over a byte pool, free and used descriptor tables in
// two dual-port synchronous memories, with merge of adjoining free blocks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_data  (req_t)
//  out     | output    | out_valid/out_stall | out_data (rsp_t)
//  cfg     | input     | cfg_we              | cfg_wdata (pool size)
//
// One transaction at a time. Alloc and free take one pass over both tables
// at once, then an apply step. A free merges with a second pass over the
// free table; when the last used block is returned every free entry gets
// its own pass.
// Init and reset sweep both memories; no request is taken then.
// The result register lets a new request enter while the last result stalls.
module first_fit_segment_allocator
  import ffsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_data,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  // Descriptor memories.
  seg_t free_mem [SEG_N];
  seg_t used_mem [SEG_N];
  seg_t free_rd, used_rd;

  logic             free_we, used_we;
  logic [IDX_W-1:0] free_waddr, used_waddr, raddr;
  seg_t             free_wdata, used_wdata;

  state_t state, state_next;

  // Control and request registers.
  logic [LEN_W-1:0]  pool_size;
  logic [LEN_W-1:0]  free_total;
  logic [CNT_W-1:0]  spare_count;
  logic              init_mode;
  logic [CNT_W-1:0]  idx;
  logic              pv;
  logic [IDX_W-1:0]  tag;
  req_t              req;
  logic [2:0]        r_status;
  logic [ADDR_W-1:0] r_grant;

  // Scan results: candidate (fit or address hit) and empty slot.
  logic              cand_found, slot_found;
  logic [IDX_W-1:0]  cand_idx, slot_idx;
  logic [ADDR_W-1:0] cand_base;
  logic [LEN_W-1:0]  cand_len;
  logic [1:0]        used_cnt;

  // Merge registers.
  logic [IDX_W-1:0]  p;
  logic              single;
  logic [ADDR_W-1:0] m_base;
  logic [LEN_W-1:0]  m_len;
  logic              mfound;
  logic [IDX_W-1:0]  m_idx;
  logic [LEN_W-1:0]  mj_len;

  logic [LEN_W-1:0] pool_clamp;
  logic             accept, scan_end, last_p, exact, ok_alloc, ok_free;
  logic             clear_last;
  logic [LEN_W-1:0] m_end;
  seg_t             scan_cand;

  assign pool_clamp = pool_size > POOL_LIMIT ? POOL_LIMIT : pool_size;
  assign accept     = in_valid && !in_stall;
  assign in_stall   = state != S_IDLE;
  assign scan_end   = idx == CNT_W'(SEG_N) && !pv;
  assign last_p     = p == IDX_W'(SEG_N - 1);
  assign clear_last = idx == CNT_W'(SEG_N - 1);
  assign exact      = cand_len == req.request_size;
  assign ok_alloc   = cand_found && (exact ? slot_found : (slot_found && spare_count != '0));
  assign ok_free    = cand_found && slot_found;
  assign m_end      = LEN_W'(m_base) + m_len;
  // Candidate comes from the free table for alloc, from the used table for free.
  assign scan_cand  = req.req_type == REQ_ALLOC ? free_rd : used_rd;

  // Memory ports: registered read, one write each.
  always_comb begin
    raddr = idx[IDX_W-1:0];
    if (state == S_MRD) begin
      raddr = p;
    end
  end

  always_ff @(posedge clk) begin
    free_rd <= free_mem[raddr];
    used_rd <= used_mem[raddr];
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory writes.
  always_comb begin
    state_next = state;
    free_we    = 1'b0;
    used_we    = 1'b0;
    free_waddr = idx[IDX_W-1:0];
    used_waddr = idx[IDX_W-1:0];
    free_wdata = '0;
    used_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        free_we = 1'b1;
        used_we = 1'b1;
        if (init_mode && idx == '0 && pool_clamp != '0) begin
          free_wdata = '{valid: 1'b1, len: pool_clamp, base: '0};
        end
        if (clear_last) begin
          state_next = init_mode ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.req_type)
            REQ_ALLOC: state_next = in_data.request_size == '0 ? S_DONE : S_SCAN;
            REQ_FREE:  state_next = S_SCAN;
            REQ_INIT:  state_next = S_CLEAR;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        state_next = S_DONE;
        if (req.req_type == REQ_ALLOC) begin
          if (ok_alloc) begin
            used_we    = 1'b1;
            used_waddr = slot_idx;
            used_wdata = '{valid: 1'b1, len: req.request_size, base: cand_base};
            free_we    = 1'b1;
            free_waddr = cand_idx;
            if (exact) begin
              free_wdata = '{valid: 1'b0, len: cand_len, base: cand_base};
            end else begin
              free_wdata = '{valid: 1'b1, len: cand_len - req.request_size,
                             base: cand_base + req.request_size[ADDR_W-1:0]};
            end
          end
        end else if (ok_free) begin
          free_we    = 1'b1;
          free_waddr = slot_idx;
          free_wdata = '{valid: 1'b1, len: cand_len, base: cand_base};
          used_we    = 1'b1;
          used_waddr = cand_idx;
          used_wdata = '{valid: 1'b0, len: cand_len, base: cand_base};
          state_next = used_cnt == 2'd2 ? S_MSCAN : S_MRD;
        end
      end
      S_MRD:  state_next = S_MCHK;
      S_MCHK: begin
        if (free_rd.valid) begin
          state_next = S_MSCAN;
        end else begin
          state_next = last_p ? S_DONE : S_MRD;
        end
      end
      S_MSCAN: begin
        if (scan_end) begin
          state_next = S_MWR;
        end
      end
      S_MWR: begin
        if (mfound) begin
          free_we    = 1'b1;
          free_waddr = m_idx;
          free_wdata = '{valid: 1'b1, len: mj_len + m_len, base: m_base};
          state_next = S_MDEL;
        end else begin
          state_next = (single || last_p) ? S_DONE : S_MRD;
        end
      end
      S_MDEL: begin
        free_we    = 1'b1;
        free_waddr = p;
        free_wdata = '{valid: 1'b0, len: m_len, base: m_base};
        state_next = (single || last_p) ? S_DONE : S_MRD;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size   <= POOL_LIMIT;
      free_total  <= '0;
      spare_count <= '0;
      init_mode   <= 1'b0;
      idx         <= '0;
      pv          <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_size <= cfg_wdata;
      end
      // Drop the result once taken; the done state loads the next one itself.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (clear_last && init_mode) begin
            free_total  <= pool_clamp;
            spare_count <= pool_clamp == '0 ? CNT_W'(SEG_N) : CNT_W'(SEG_N - 1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            req        <= in_data;
            r_status   <= ST_OK;
            r_grant    <= '0;
            idx        <= '0;
            pv         <= 1'b0;
            cand_found <= 1'b0;
            slot_found <= 1'b0;
            used_cnt   <= '0;
            init_mode  <= in_data.req_type == REQ_INIT;
            if (in_data.req_type == REQ_ALLOC && in_data.request_size == '0) begin
              r_status <= ST_BADSIZE;
            end
          end
        end
        S_SCAN, S_MSCAN: begin
          // Issue one read per cycle; evaluate the entry read the cycle before.
          if (idx != CNT_W'(SEG_N)) begin
            idx <= idx + 1'b1;
            tag <= idx[IDX_W-1:0];
            pv  <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv && state == S_SCAN) begin
            if (req.req_type == REQ_ALLOC) begin
              if (!cand_found && scan_cand.valid && scan_cand.len >= req.request_size) begin
                cand_found <= 1'b1;
                cand_idx   <= tag;
                cand_base  <= scan_cand.base;
                cand_len   <= scan_cand.len;
              end
              if (!slot_found && !used_rd.valid) begin
                slot_found <= 1'b1;
                slot_idx   <= tag;
              end
            end else begin
              if (!cand_found && scan_cand.valid && scan_cand.base == req.block_address) begin
                cand_found <= 1'b1;
                cand_idx   <= tag;
                cand_base  <= scan_cand.base;
                cand_len   <= scan_cand.len;
              end
              if (!slot_found && !free_rd.valid) begin
                slot_found <= 1'b1;
                slot_idx   <= tag;
              end
              if (used_rd.valid && used_cnt != 2'd2) begin
                used_cnt <= used_cnt + 1'b1;
              end
            end
          end
          if (pv && state == S_MSCAN && !mfound && free_rd.valid && tag != p &&
              LEN_W'(free_rd.base) == m_end) begin
            mfound <= 1'b1;
            m_idx  <= tag;
            mj_len <= free_rd.len;
          end
        end
        S_APPLY: begin
          if (req.req_type == REQ_ALLOC) begin
            if (!cand_found) begin
              r_status <= ST_NOFIT;
            end else if (!ok_alloc) begin
              r_status <= ST_NOSPARE;
            end else begin
              r_grant    <= cand_base;
              free_total <= free_total - req.request_size;
              if (!exact) begin
                spare_count <= spare_count - 1'b1;
              end
            end
          end else if (!cand_found) begin
            r_status <= ST_NOADDR;
          end else if (!slot_found) begin
            r_status <= ST_NOSPARE;
          end else begin
            free_total <= free_total + cand_len;
            single     <= used_cnt == 2'd2;
            p          <= used_cnt == 2'd2 ? slot_idx : '0;
            m_base     <= cand_base;
            m_len      <= cand_len;
            mfound     <= 1'b0;
            idx        <= '0;
            pv         <= 1'b0;
          end
        end
        S_MCHK: begin
          if (free_rd.valid) begin
            m_base <= free_rd.base;
            m_len  <= free_rd.len;
            mfound <= 1'b0;
            idx    <= '0;
            pv     <= 1'b0;
          end else if (!last_p) begin
            p <= p + 1'b1;
          end
        end
        S_MWR: begin
          if (mfound) begin
            spare_count <= spare_count + 1'b1;
          end else if (!single && !last_p) begin
            p <= p + 1'b1;
          end
        end
        S_MDEL: begin
          if (!single && !last_p) begin
            p <= p + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= '{status: r_status,
                           granted_address: r_status == ST_OK ? r_grant : '0,
                           bytes_free: free_total};
            init_mode <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks.
  a_spare_bound: assert property (@(posedge clk) disable iff (rst)
    spare_count <= CNT_W'(SEG_N))
    else $error("spare descriptor count above table depth");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= POOL_LIMIT)
    else $error("free byte total above pool limit");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted transaction left the controller idle");

  a_used_write: assert property (@(posedge clk) disable iff (rst)
    used_we |-> (state == S_APPLY || state == S_CLEAR))
    else $error("used table written outside apply or clear");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit segment allocator. A directed table
// covers the corner requests, then random allocate/free traffic runs under
// several pool sizes. Every response is compared against a fixed expectation
// from the table or against an in-bench model of the descriptor tables.
// ----------------------------------------------------------------------------
module tb;
  import ffsa_pkg::*;

  // Request code with no operation behind it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  first_fit_segment_allocator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Allocator model: its own copy of both descriptor tables and the pool
  // register. Unwritten bases and lengths are only read behind a valid bit.
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] hole_base[SEG_N];
  logic [LEN_W-1:0]  hole_len[SEG_N];
  bit                hole_live[SEG_N];
  logic [ADDR_W-1:0] grant_base[SEG_N];
  logic [LEN_W-1:0]  grant_len[SEG_N];
  bit                grant_live[SEG_N];
  logic [LEN_W-1:0]  free_bytes = '0;
  int                spare_desc = 0;
  logic [LEN_W-1:0]  pool_bytes = POOL_LIMIT;

  rsp_t response_queue[$];
  int   mismatches = 0;
  int   responses_seen = 0;
  bit   hold_done = 0;

  function automatic int first_hole(input bit live[SEG_N]);
    for (int i = 0; i < SEG_N; i++) if (!live[i]) return i;
    return SEG_N;
  endfunction

  // Fold hole p into a hole that starts right where p ends.
  function automatic void fold_hole(input int p);
    int tail;
    tail = int'(hole_base[p]) + int'(hole_len[p]);
    for (int j = 0; j < SEG_N; j++) begin
      if (j != p && hole_live[j] && int'(hole_base[j]) == tail) begin
        hole_len[j] = hole_len[j] + hole_len[p];
        hole_base[j] = hole_base[p];
        hole_live[p] = 0;
        spare_desc++;
        return;
      end
    end
  endfunction

  function automatic logic [2:0] grant_bytes(input logic [LEN_W-1:0] size,
                                             output logic [ADDR_W-1:0] addr);
    int i, k;
    if (size == 0) return ST_BADSIZE;
    for (i = 0; i < SEG_N; i++) if (hole_live[i] && hole_len[i] >= size) break;
    if (i >= SEG_N) return ST_NOFIT;
    k = first_hole(grant_live);
    if (hole_len[i] == size) begin
      if (k >= SEG_N) return ST_NOSPARE;
      grant_base[k] = hole_base[i];
      hole_live[i] = 0;
    end else begin
      if (spare_desc == 0 || k >= SEG_N) return ST_NOSPARE;
      grant_base[k] = hole_base[i];
      hole_base[i] = hole_base[i] + size[ADDR_W-1:0];
      hole_len[i] = hole_len[i] - size;
      spare_desc--;
    end
    grant_len[k] = size;
    grant_live[k] = 1;
    free_bytes = free_bytes - size;
    addr = grant_base[k];
    return ST_OK;
  endfunction

  function automatic logic [2:0] return_block(input logic [ADDR_W-1:0] addr);
    int i, k;
    bit any_granted;
    any_granted = 0;
    for (i = 0; i < SEG_N; i++) if (grant_live[i] && grant_base[i] == addr) break;
    if (i >= SEG_N) return ST_NOADDR;
    k = first_hole(hole_live);
    if (k >= SEG_N) return ST_NOSPARE;
    hole_base[k] = grant_base[i];
    hole_len[k] = grant_len[i];
    hole_live[k] = 1;
    grant_live[i] = 0;
    free_bytes = free_bytes + grant_len[i];
    for (int j = 0; j < SEG_N; j++) if (grant_live[j]) any_granted = 1;
    if (any_granted) fold_hole(k);
    else for (int j = 0; j < SEG_N; j++) if (hole_live[j]) fold_hole(j);
    return ST_OK;
  endfunction

  function automatic rsp_t predict_response(input req_t r);
    rsp_t res;
    logic [LEN_W-1:0] sz;
    res = '0;
    if (r.req_type == REQ_ALLOC) begin
      res.status = grant_bytes(r.request_size, res.granted_address);
    end else if (r.req_type == REQ_FREE) begin
      res.status = return_block(r.block_address);
    end else if (r.req_type == REQ_INIT) begin
      sz = (pool_bytes > POOL_LIMIT) ? POOL_LIMIT : pool_bytes;
      for (int j = 0; j < SEG_N; j++) begin
        hole_live[j] = 0;
        grant_live[j] = 0;
      end
      if (sz == 0) begin
        spare_desc = SEG_N;
      end else begin
        hole_base[0] = '0;
        hole_len[0] = sz;
        hole_live[0] = 1;
        spare_desc = SEG_N - 1;
      end
      free_bytes = sz;
    end
    if (res.status != ST_OK) res.granted_address = '0;
    res.bytes_free = free_bytes;
    return res;
  endfunction

  function automatic int granted_count();
    int n;
    n = 0;
    for (int j = 0; j < SEG_N; j++) if (grant_live[j]) n++;
    return n;
  endfunction

  // Pick the base of a live grant at random; the caller knows one exists.
  function automatic logic [ADDR_W-1:0] pick_granted();
    int pick, n;
    pick = $urandom_range(granted_count() - 1);
    n = 0;
    for (int j = 0; j < SEG_N; j++) begin
      if (grant_live[j]) begin
        if (n == pick) return grant_base[j];
        n++;
      end
    end
    return '0;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: drive on the falling edge, hold valid and payload until
  // the rising edge where stall is low, then either chain the next
  // transaction in a burst or drop valid for a gap.
  // --------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_request(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t guess;
    int gap;
    if (burst_left == 0) begin
      // End of burst: idle for a random gap, sometimes none at all.
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    guess = predict_response(r);
    response_queue.push_back(typed ? typed_rsp : guess);
    in_data = r;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    @(negedge clk);
    // Drop valid unless the next call keeps it up; a new item overwrites it.
    if (burst_left == 0) in_valid = 1'b0;
  endtask

  // Quiesce: wait for every response, then let the block settle.
  task automatic wait_idle();
    in_valid = 1'b0;
    burst_left = 0;
    while (response_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_pool(input logic [LEN_W-1:0] value);
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    pool_bytes = value;
  endtask

  function automatic req_t make_req(input logic [1:0] kind, input logic [LEN_W-1:0] size,
                                    input logic [ADDR_W-1:0] addr);
    req_t r;
    r.req_type = kind;
    r.request_size = size;
    r.block_address = addr;
    return r;
  endfunction

  // Random request: mostly well-formed allocs and frees of live blocks.
  // Returning the last live block forces a merge pass for every free entry
  // (very slow), so keep that rare.
  function automatic req_t random_req();
    int roll;
    roll = $urandom_range(99);
    if (roll < 62) begin
      case ($urandom_range(9))
        0:       return make_req(REQ_ALLOC, LEN_W'($urandom()), ADDR_W'($urandom()));
        1:       return make_req(REQ_ALLOC, '0, ADDR_W'($urandom()));
        default: return make_req(REQ_ALLOC, LEN_W'($urandom_range(1, 2048)),
                                 ADDR_W'($urandom()));
      endcase
    end else if (roll < 95) begin
      if (granted_count() > 1 || (granted_count() == 1 && $urandom_range(40) == 0))
        if ($urandom_range(4) != 0)
          return make_req(REQ_FREE, LEN_W'($urandom()), pick_granted());
      return make_req(REQ_FREE, LEN_W'($urandom()), ADDR_W'($urandom()));
    end else if (roll < 97) begin
      return make_req(REQ_INIT, LEN_W'($urandom()), ADDR_W'($urandom()));
    end
    return make_req(REQ_UNUSED, LEN_W'($urandom()), ADDR_W'($urandom()));
  endfunction

  // Directed table. Typed rows carry a response that follows straight from
  // the request; the rest go through the model.
  typedef struct {
    req_t r;
    bit   typed;
    rsp_t rsp;
  } row_t;

  row_t directed[] = '{
    // Before init: nothing to allocate, nothing to return.
    '{'{REQ_ALLOC, 17'd16, 16'd0},         1, '{ST_NOFIT, 16'd0, 17'd0}},
    '{'{REQ_FREE, 17'd0, 16'd0},           1, '{ST_NOADDR, 16'd0, 17'd0}},
    // Unused request type is a no-op.
    '{'{REQ_UNUSED, 17'h1ffff, 16'hffff},  1, '{ST_OK, 16'd0, 17'd0}},
    '{'{REQ_INIT, 17'd0, 16'd0},           1, '{ST_OK, 16'd0, 17'd65536}},
    '{'{REQ_ALLOC, 17'd0, 16'hffff},       1, '{ST_BADSIZE, 16'd0, 17'd65536}},
    '{'{REQ_ALLOC, 17'h1ffff, 16'd0},      1, '{ST_NOFIT, 16'd0, 17'd65536}},
    // Whole pool in one exact fit, then give it back (last live block).
    '{'{REQ_ALLOC, 17'd65536, 16'd0},      1, '{ST_OK, 16'd0, 17'd0}},
    '{'{REQ_FREE, 17'd0, 16'd0},           1, '{ST_OK, 16'd0, 17'd65536}},
    '{'{REQ_ALLOC, 17'd100, 16'd0},        0, '{default: '0}},
    '{'{REQ_ALLOC, 17'd200, 16'd0},        0, '{default: '0}},
    '{'{REQ_ALLOC, 17'd1, 16'd0},          0, '{default: '0}},
    '{'{REQ_FREE, 17'd0, 16'h1234},        0, '{default: '0}},
    '{'{REQ_FREE, 17'd0, 16'd100},         0, '{default: '0}},
    '{'{REQ_FREE, 17'd0, 16'd0},           0, '{default: '0}},
    '{'{REQ_ALLOC, 17'd300, 16'd0},        0, '{default: '0}},
    '{'{REQ_FREE, 17'd0, 16'd0},           0, '{default: '0}},
    '{'{REQ_FREE, 17'd0, 16'd300},         0, '{default: '0}},
    '{'{REQ_INIT, 17'd0, 16'd0},           0, '{default: '0}}
  };

  // Pool sizes per phase: oversized, smallest, empty, middling, full.
  logic [LEN_W-1:0] phase_pool[5] = '{17'h1ffff, 17'd1, 17'd0, 17'd3000, 17'd65536};
  int               phase_items[5] = '{85, 10, 10, 85, 85};

  initial begin
    rsp_t none;
    none = '0;
    for (int j = 0; j < SEG_N; j++) begin
      hole_live[j] = 0;
      grant_live[j] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_request(directed[i].r, directed[i].typed, directed[i].rsp);

    foreach (phase_pool[p]) begin
      wait_idle();
      write_pool(phase_pool[p]);
      send_request(make_req(REQ_INIT, '0, '0), 0, none);
      repeat (phase_items[p]) send_request(random_req(), 0, none);
    end

    in_valid = 1'b0;
    while (response_queue.size() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: stall on a pattern that changes at random, and once
  // hold off for a long stretch so the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin
    int mode, hold_left;
    mode = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (($urandom_range(63)) == 0) mode = $urandom_range(2);
      if (!hold_done && responses_seen == 40) begin
        hold_done = 1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(9) < 3);
          default: out_stall = ($urandom_range(9) < 7);
        endcase
      end
    end
  end

  // Compare each accepted response with the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      responses_seen++;
      if (response_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", out_data);
      end else begin
        want = response_queue.pop_front();
        if (out_data.status !== want.status ||
            out_data.granted_address !== want.granted_address ||
            out_data.bytes_free !== want.bytes_free) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response %0d mismatch: expected st=%0d addr=%0h free=%0d, got st=%0d addr=%0h free=%0d",
                     responses_seen, want.status, want.granted_address, want.bytes_free,
                     out_data.status, out_data.granted_address, out_data.bytes_free);
        end
      end
    end
  end

  // Watchdog: full merge passes are slow.
  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
